// ----- rtl/core/cpv_pkg.sv -----
// Shared types and constants for the Chebyshev position/velocity unit.
// Used by cpv_mul_unit and chebyshev_position_velocity_unit; no dependencies.
package cpv_pkg;

  // Width of coefficients, accumulators and multiplier operands
  localparam int unsigned DATA_W = 64;
  // Width of one multiplier digit
  localparam int unsigned DIGIT_W = 32;

  // Request from the sequencer to the shared multiplier
  typedef struct packed {
    logic start;      // capture operands and begin
    logic round_q30;  // 1: round and shift by 30, 0: by 29
  } mul_req_t;

  // Status from the shared multiplier
  typedef struct packed {
    logic busy;  // a multiply is in progress
    logic done;  // product is valid this cycle
    logic clip;  // product saturated to 64 bits
  } mul_rsp_t;

endpackage

// ----- rtl/core/cpv_mul_unit.sv -----
// Iterative signed 64x64 multiplier with round-half-away, right shift and 64-bit saturation.
// One 32x32 multiplier is stepped over four digit pairs. Depends on cpv_pkg.
module cpv_mul_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  cpv_pkg::mul_req_t                 req,
  input  logic signed [cpv_pkg::DATA_W-1:0] op_a,
  input  logic signed [cpv_pkg::DATA_W-1:0] op_b,
  output cpv_pkg::mul_rsp_t                 rsp,
  output logic signed [cpv_pkg::DATA_W-1:0] product
);

  localparam int unsigned DW = cpv_pkg::DATA_W;
  localparam int unsigned GW = cpv_pkg::DIGIT_W;
  localparam int unsigned PW = 2 * DW;

  typedef enum logic [2:0] {
    M_IDLE,
    M_MUL,
    M_ROUND,
    M_CLAMP,
    M_SIGN
  } mstate_t;

  mstate_t         state;
  logic [DW-1:0]   mag_a;
  logic [DW-1:0]   mag_b;
  logic            neg;
  logic            sh30;
  logic [2:0]      step;
  logic [DW-1:0]   pp;
  logic [1:0]      pp_pos;
  logic [PW-1:0]   acc;
  logic [DW-1:0]   mag;
  logic            clip;

  logic [GW-1:0]   dig_a;
  logic [GW-1:0]   dig_b;
  logic [DW-1:0]   pp_next;
  logic [PW-1:0]   pp_shifted;
  logic [PW-1:0]   quot;
  logic [DW-1:0]   lim;

  // Digit selection: step[1] picks the digit of a, step[0] the digit of b
  assign dig_a   = step[1] ? mag_a[DW-1:GW] : mag_a[GW-1:0];
  assign dig_b   = step[0] ? mag_b[DW-1:GW] : mag_b[GW-1:0];
  assign pp_next = DW'(dig_a) * DW'(dig_b);

  // Align the registered partial product by its digit weight
  always_comb begin
    case (pp_pos)
      2'd0:    pp_shifted = PW'(pp);
      2'd1:    pp_shifted = PW'(pp) << GW;
      2'd2:    pp_shifted = PW'(pp) << (2 * GW);
      default: pp_shifted = '0;
    endcase
  end

  // Shifted magnitude and its saturation limit
  assign quot = sh30 ? (acc >> 30) : (acc >> 29);
  assign lim  = neg ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};

  // Sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= M_IDLE;
      step  <= '0;
      clip  <= 1'b0;
    end else begin
      case (state)
        M_IDLE: begin
          if (req.start) begin
            mag_a <= op_a[DW-1] ? (~op_a + 1'b1) : op_a;
            mag_b <= op_b[DW-1] ? (~op_b + 1'b1) : op_b;
            neg   <= op_a[DW-1] ^ op_b[DW-1];
            sh30  <= req.round_q30;
            acc   <= '0;
            step  <= '0;
            state <= M_MUL;
          end
        end
        M_MUL: begin
          // multiply one digit pair, add the previous one
          if (step != 3'd4) begin
            pp     <= pp_next;
            pp_pos <= 2'(step[1]) + 2'(step[0]);
          end
          if (step != 3'd0) begin
            acc <= acc + pp_shifted;
          end
          if (step == 3'd4) begin
            state <= M_ROUND;
          end
          step <= step + 3'd1;
        end
        M_ROUND: begin
          acc   <= acc + (sh30 ? (PW'(1) << 29) : (PW'(1) << 28));
          state <= M_CLAMP;
        end
        M_CLAMP: begin
          if ((quot[PW-1:DW] != '0) || (quot[DW-1:0] > lim)) begin
            clip <= 1'b1;
            mag  <= lim;
          end else begin
            clip <= 1'b0;
            mag  <= quot[DW-1:0];
          end
          state <= M_SIGN;
        end
        M_SIGN: begin
          state <= M_IDLE;
        end
        default: begin
          state <= M_IDLE;
        end
      endcase
    end
  end

  // Apply the sign on the way out
  assign product  = neg ? (~mag + 1'b1) : mag;
  assign rsp.busy = (state != M_IDLE);
  assign rsp.done = (state == M_SIGN);
  assign rsp.clip = clip;

endmodule

// ----- rtl/core/chebyshev_position_velocity_unit.sv -----
// Chebyshev position/velocity evaluator: one coefficient per transaction.
// Index 0 and terms past MAX_TERMS need no multiply, index 1 takes two multiplies and
// later terms four, all on the shared multiplier. The unit holds in_ready low until the
// coefficient is done, so it takes no new coefficient before the last one is finished;
// a last term also waits while the output register holds a result not yet taken.
// Synchronous active-high reset clears sums, recurrences, counters and out_valid.
// Depends on cpv_pkg and cpv_mul_unit.
module chebyshev_position_velocity_unit #(
  parameter int unsigned MAX_TERMS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [31:0]                cheb_time,
  input  logic signed [cpv_pkg::DATA_W-1:0] coefficient,
  input  logic                              first_term,
  input  logic                              last_term,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [cpv_pkg::DATA_W-1:0] position_value,
  output logic signed [cpv_pkg::DATA_W-1:0] velocity_value,
  output logic [1:0]                        axis_index,
  output logic                              saturated
);

  localparam int unsigned DW    = cpv_pkg::DATA_W;
  localparam int unsigned TC_W  = $clog2(MAX_TERMS + 1);
  localparam int unsigned T_W   = 34;
  localparam int unsigned V_W   = 42;
  localparam logic [1:0]  AXIS_LAST = 2'd2;
  localparam logic signed [T_W-1:0] T_ONE = T_W'(64'sd1 << 30);
  localparam logic signed [V_W-1:0] V_ONE = V_W'(64'sd1 << 30);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_TT_GO,
    S_TT_WAIT,
    S_TV_GO,
    S_TV_WAIT,
    S_CT_GO,
    S_CT_WAIT,
    S_CV_GO,
    S_CV_WAIT,
    S_EMIT
  } state_t;

  state_t                  state;
  logic signed [31:0]      t_reg;
  logic signed [DW-1:0]    coef_reg;
  logic                    first_reg;
  logic                    last_reg;
  logic signed [T_W-1:0]   poly_prev;
  logic signed [T_W-1:0]   poly_prev2;
  logic signed [V_W-1:0]   deriv_prev;
  logic signed [V_W-1:0]   deriv_prev2;
  logic signed [T_W-1:0]   tj;
  logic signed [V_W-1:0]   vj;
  logic signed [DW-1:0]    position_acc;
  logic signed [DW-1:0]    velocity_acc;
  logic [TC_W-1:0]         term_count;
  logic [1:0]              axis_count;
  logic                    clip_flag;

  cpv_pkg::mul_req_t       mul_req;
  cpv_pkg::mul_rsp_t       mul_rsp;
  logic signed [DW-1:0]    mul_a;
  logic signed [DW-1:0]    mul_b;
  logic signed [DW-1:0]    mul_p;

  logic signed [65:0]      t_diff;
  logic                    t_ovf;
  logic signed [T_W-1:0]   t_clamped;
  logic signed [66:0]      v_sum;
  logic                    v_ovf;
  logic signed [V_W-1:0]   v_clamped;
  logic signed [DW:0]      pos_sum;
  logic signed [DW:0]      vel_sum;
  logic                    pos_ovf;
  logic                    vel_ovf;
  logic signed [DW-1:0]    pos_sat;
  logic signed [DW-1:0]    vel_sat;
  logic                    out_free;
  logic                    emit;

  // Shared multiplier
  cpv_mul_unit u_mul (
    .clk     (clk),
    .rst     (rst),
    .req     (mul_req),
    .op_a    (mul_a),
    .op_b    (mul_b),
    .rsp     (mul_rsp),
    .product (mul_p)
  );

  // Operand selection per multiply step
  always_comb begin
    mul_req.start     = 1'b0;
    mul_req.round_q30 = 1'b1;
    mul_a             = coef_reg;
    mul_b             = DW'(tj);
    case (state)
      S_TT_GO: begin
        mul_req.start     = 1'b1;
        mul_req.round_q30 = 1'b0;
        mul_a             = DW'(t_reg);
        mul_b             = DW'(poly_prev);
      end
      S_TV_GO: begin
        mul_req.start     = 1'b1;
        mul_req.round_q30 = 1'b0;
        mul_a             = DW'(t_reg);
        mul_b             = DW'(deriv_prev);
      end
      S_CT_GO: begin
        mul_req.start = 1'b1;
        mul_b         = DW'(tj);
      end
      S_CV_GO: begin
        mul_req.start = 1'b1;
        mul_b         = DW'(vj);
      end
      default: begin
        mul_req.start = 1'b0;
      end
    endcase
  end

  // T_j = 2t*T_{j-1} - T_{j-2}, clamped to 34 bits
  assign t_diff    = 66'(mul_p) - 66'(poly_prev2);
  assign t_ovf     = !((t_diff[65:T_W-1] == '0) || (t_diff[65:T_W-1] == '1));
  assign t_clamped = !t_ovf ? t_diff[T_W-1:0] :
                     (t_diff[65] ? {1'b1, {(T_W-1){1'b0}}} : {1'b0, {(T_W-1){1'b1}}});

  // V_j = 2t*V_{j-1} + 2*T_{j-1} - V_{j-2}, clamped to 42 bits
  assign v_sum     = 67'(mul_p) + (67'(poly_prev) <<< 1) - 67'(deriv_prev2);
  assign v_ovf     = !((v_sum[66:V_W-1] == '0) || (v_sum[66:V_W-1] == '1));
  assign v_clamped = !v_ovf ? v_sum[V_W-1:0] :
                     (v_sum[66] ? {1'b1, {(V_W-1){1'b0}}} : {1'b0, {(V_W-1){1'b1}}});

  // Saturating accumulator adds
  assign pos_sum = (DW+1)'(position_acc) + (DW+1)'(mul_p);
  assign vel_sum = (DW+1)'(velocity_acc) + (DW+1)'(mul_p);
  assign pos_ovf = pos_sum[DW] != pos_sum[DW-1];
  assign vel_ovf = vel_sum[DW] != vel_sum[DW-1];
  assign pos_sat = !pos_ovf ? pos_sum[DW-1:0] :
                   (pos_sum[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}});
  assign vel_sat = !vel_ovf ? vel_sum[DW-1:0] :
                   (vel_sum[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}});

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;
  assign emit     = (state == S_EMIT) && last_reg && out_free;

  // Sequencer, recurrence state, accumulators and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      poly_prev    <= '0;
      poly_prev2   <= '0;
      deriv_prev   <= '0;
      deriv_prev2  <= '0;
      position_acc <= '0;
      velocity_acc <= '0;
      term_count   <= '0;
      axis_count   <= '0;
      clip_flag    <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      // output register: load on a last term, clear once taken
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            t_reg     <= cheb_time;
            coef_reg  <= coefficient;
            first_reg <= first_term;
            last_reg  <= last_term;
            state     <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          if (first_reg || (term_count == '0)) begin
            // index zero: restart the series
            position_acc <= coef_reg;
            velocity_acc <= '0;
            clip_flag    <= 1'b0;
            poly_prev    <= T_ONE;
            poly_prev2   <= '0;
            deriv_prev   <= '0;
            deriv_prev2  <= '0;
            term_count   <= TC_W'(1);
            state        <= S_EMIT;
          end else if (term_count >= TC_W'(MAX_TERMS)) begin
            state <= S_EMIT;
          end else if (term_count == TC_W'(1)) begin
            tj    <= T_W'(t_reg);
            vj    <= V_ONE;
            state <= S_CT_GO;
          end else begin
            state <= S_TT_GO;
          end
        end
        S_TT_GO: state <= S_TT_WAIT;
        S_TT_WAIT: begin
          if (mul_rsp.done) begin
            tj <= t_clamped;
            if (mul_rsp.clip || t_ovf) begin
              clip_flag <= 1'b1;
            end
            state <= S_TV_GO;
          end
        end
        S_TV_GO: state <= S_TV_WAIT;
        S_TV_WAIT: begin
          if (mul_rsp.done) begin
            vj <= v_clamped;
            if (mul_rsp.clip || v_ovf) begin
              clip_flag <= 1'b1;
            end
            state <= S_CT_GO;
          end
        end
        S_CT_GO: state <= S_CT_WAIT;
        S_CT_WAIT: begin
          if (mul_rsp.done) begin
            position_acc <= pos_sat;
            if (mul_rsp.clip || pos_ovf) begin
              clip_flag <= 1'b1;
            end
            state <= S_CV_GO;
          end
        end
        S_CV_GO: state <= S_CV_WAIT;
        S_CV_WAIT: begin
          if (mul_rsp.done) begin
            velocity_acc <= vel_sat;
            if (mul_rsp.clip || vel_ovf) begin
              clip_flag <= 1'b1;
            end
            poly_prev2  <= poly_prev;
            poly_prev   <= tj;
            deriv_prev2 <= deriv_prev;
            deriv_prev  <= vj;
            term_count  <= term_count + TC_W'(1);
            state       <= S_EMIT;
          end
        end
        S_EMIT: begin
          // last term: hand the sums to the output register once it is free
          if (!last_reg) begin
            state <= S_IDLE;
          end else if (out_free) begin
            position_value <= position_acc;
            velocity_value <= velocity_acc;
            axis_index     <= axis_count;
            saturated      <= clip_flag;
            axis_count     <= (axis_count >= AXIS_LAST) ? 2'd0 : axis_count + 2'd1;
            term_count     <= '0;
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Multiplier results arrive only while the sequencer waits for one
  assert property (@(posedge clk) disable iff (rst)
    mul_rsp.done |-> (state == S_TT_WAIT || state == S_TV_WAIT ||
                      state == S_CT_WAIT || state == S_CV_WAIT))
    else $error("multiplier finished outside a wait state");

  // No new transaction while the multiplier is still working
  assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !mul_rsp.busy)
    else $error("input ready while multiplier busy");

  // Term counter never passes its limit
  assert property (@(posedge clk) disable iff (rst)
    term_count <= TC_W'(MAX_TERMS))
    else $error("term counter overrun");

  // Axis counter stays within x, y, z
  assert property (@(posedge clk) disable iff (rst)
    axis_count <= AXIS_LAST)
    else $error("axis counter out of range");

endmodule
